FILE: sv/hcbd_pkg.sv
// Shared types, constants and helpers for the HTTP chunked body decoder.
package hcbd_pkg;

  localparam int LENGTH_WIDTH_DEF = 32;
  localparam int CFG_ADDR_W       = 3;

  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  localparam logic [31:0] LEN_ALL_ONES = 32'hffff_ffff;

  typedef enum logic [2:0] {
    KIND_FRAME  = 3'd0,
    KIND_BODY   = 3'd1,
    KIND_END    = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_IGNORE = 3'd4
  } kind_t;

  typedef struct packed {
    logic        chunked_mode;
    logic [31:0] content_length;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] body_count;
  } result_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

FILE: sv/hcbd_regs.sv
// APB configuration registers: transfer mode and content length.
module hcbd_regs
  import hcbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  typedef enum logic {
    REG_CHUNKED_MODE   = 1'b0,
    REG_CONTENT_LENGTH = 1'b1
  } reg_idx_t;

  reg_idx_t idx;
  logic     wr_en;
  cfg_t     cfg_r;

  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chunked_mode   <= 1'b0;
      cfg_r.content_length <= LEN_ALL_ONES;
    end else if (wr_en) begin
      case (idx)
        REG_CHUNKED_MODE:   cfg_r.chunked_mode   <= pwdata[0];
        REG_CONTENT_LENGTH: cfg_r.content_length <= pwdata;
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CHUNKED_MODE:   prdata = {31'd0, cfg_r.chunked_mode};
      REG_CONTENT_LENGTH: prdata = cfg_r.content_length;
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/hcbd_core.sv
// Decoder state and per-byte next-state logic for chunked and identity bodies.
module hcbd_core
  import hcbd_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  cfg_t       cfg,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_SIZE = 3'd0,
    PH_DATA = 3'd1,
    PH_CEND = 3'd2,
    PH_LAST = 3'd3,
    PH_DONE = 3'd4,
    PH_ERR  = 3'd5
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [LENGTH_WIDTH-1:0] chunk_left_r, chunk_left_nxt;
  logic [LENGTH_WIDTH-1:0] size_accum_r, size_accum_nxt;
  logic                    digits_seen_r, digits_seen_nxt;
  logic                    digits_closed_r, digits_closed_nxt;
  logic                    cr_pending_r, cr_pending_nxt;
  logic [31:0]             delivered_r, delivered_nxt;

  logic [4:0]              hex;
  logic                    is_blank;
  logic                    size_full;
  logic [31:0]             delivered_inc;
  logic [LENGTH_WIDTH-1:0] left_dec;
  kind_t                   kind;

  assign hex           = hex_digit(byte_in);
  assign is_blank      = (byte_in == CHAR_SP) || (byte_in == CHAR_TAB);
  assign size_full     = size_accum_r[LENGTH_WIDTH-1 -: 4] != 4'd0;
  assign delivered_inc = (delivered_r != LEN_ALL_ONES) ? delivered_r + 32'd1 : delivered_r;
  assign left_dec      = (chunk_left_r != '0) ? chunk_left_r - LENGTH_WIDTH'(1) : chunk_left_r;

  always_comb begin
    phase_nxt         = phase_r;
    chunk_left_nxt    = chunk_left_r;
    size_accum_nxt    = size_accum_r;
    digits_seen_nxt   = digits_seen_r;
    digits_closed_nxt = digits_closed_r;
    cr_pending_nxt    = cr_pending_r;
    delivered_nxt     = delivered_r;
    kind              = KIND_FRAME;

    if (!cfg.chunked_mode) begin
      if (cfg.content_length == LEN_ALL_ONES || delivered_r < cfg.content_length) begin
        delivered_nxt = delivered_inc;
        kind          = KIND_BODY;
      end else begin
        kind = KIND_IGNORE;
      end
    end else begin
      case (phase_r)
        PH_SIZE: begin
          if (cr_pending_r) begin
            cr_pending_nxt = 1'b0;
            if (byte_in == CHAR_LF) begin
              if (!digits_seen_r) begin
                phase_nxt = PH_ERR;
                kind      = KIND_ERROR;
              end else begin
                if (size_accum_r == '0) begin
                  phase_nxt = PH_LAST;
                end else begin
                  chunk_left_nxt = size_accum_r;
                  phase_nxt      = PH_DATA;
                end
                size_accum_nxt    = '0;
                digits_seen_nxt   = 1'b0;
                digits_closed_nxt = 1'b0;
              end
            end else begin
              // stray CR is line content and always ends the digit run
              digits_closed_nxt = 1'b1;
            end
          end else if (byte_in == CHAR_CR) begin
            cr_pending_nxt = 1'b1;
          end else if (!digits_closed_r) begin
            if (hex[4]) begin
              if (size_full) begin
                phase_nxt = PH_ERR;
                kind      = KIND_ERROR;
              end else begin
                size_accum_nxt  = {size_accum_r[LENGTH_WIDTH-5:0], hex[3:0]};
                digits_seen_nxt = 1'b1;
              end
            end else if (digits_seen_r || !is_blank) begin
              digits_closed_nxt = 1'b1;
            end
          end
        end
        PH_DATA: begin
          delivered_nxt  = delivered_inc;
          chunk_left_nxt = left_dec;
          if (left_dec == '0) phase_nxt = PH_CEND;
          kind = KIND_BODY;
        end
        PH_CEND, PH_LAST: begin
          if (cr_pending_r) begin
            cr_pending_nxt = 1'b0;
            if (byte_in == CHAR_LF) begin
              if (phase_r == PH_LAST) begin
                phase_nxt = PH_DONE;
                kind      = KIND_END;
              end else begin
                phase_nxt         = PH_SIZE;
                size_accum_nxt    = '0;
                digits_seen_nxt   = 1'b0;
                digits_closed_nxt = 1'b0;
              end
            end else begin
              phase_nxt = PH_ERR;
              kind      = KIND_ERROR;
            end
          end else if (byte_in == CHAR_CR) begin
            cr_pending_nxt = 1'b1;
          end else begin
            phase_nxt = PH_ERR;
            kind      = KIND_ERROR;
          end
        end
        PH_DONE: kind = KIND_IGNORE;
        default: begin
          phase_nxt = PH_ERR;
          kind      = KIND_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_SIZE;
      chunk_left_r    <= '0;
      size_accum_r    <= '0;
      digits_seen_r   <= 1'b0;
      digits_closed_r <= 1'b0;
      cr_pending_r    <= 1'b0;
      delivered_r     <= 32'd0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      chunk_left_r    <= chunk_left_nxt;
      size_accum_r    <= size_accum_nxt;
      digits_seen_r   <= digits_seen_nxt;
      digits_closed_r <= digits_closed_nxt;
      cr_pending_r    <= cr_pending_nxt;
      delivered_r     <= delivered_nxt;
    end
  end

  assign res.kind       = kind;
  assign res.data_byte  = (kind == KIND_BODY) ? byte_in : 8'd0;
  assign res.body_count = delivered_nxt;

  a_delivered_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> delivered_r >= $past(delivered_r))
    else $error("delivered count went backwards");

  a_delivered_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(delivered_r))
    else $error("delivered count moved without a byte");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("left end-of-body phase without reset");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERR |=> phase_r == PH_ERR)
    else $error("left error phase without reset");

endmodule

FILE: sv/http_chunked_body_decoder.sv
// Top level: request input register, decoder core, result register, APB config.
// A request accepted into the input register is decoded as it moves into the result
// register, from which it shows on out_*. Throughput: one byte per cycle unless out_stall
// holds a waiting result; the decoder state loop is combinational.
// While a result waits in the output register, the input register takes one more
// request and then stalls. Reset (rst_n low, synchronous): both registers empty,
// decoder at the start of a size line, counters zero, chunked_mode 0, length all ones.
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input byte stream
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  // decoded results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_kind,
  output logic [7:0]            out_data_byte,
  output logic [31:0]           out_body_count,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t       cfg;
  result_t    res;
  result_t    res_r;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  logic       advance;
  logic       step;

  hcbd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The result register frees up when empty or when its request is taken.
  assign advance  = !out_valid_r || !out_stall;
  // Decode the held byte and update the state only as it moves into the result register.
  assign step     = in_valid_r && advance;
  // Hold the input register while its byte cannot advance.
  assign in_stall = in_valid_r && !advance;

  hcbd_core #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Input register: load a new request whenever it is not stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
    end
  end

  // Result register: capture the decoded byte, drop validity once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = res_r.kind;
  assign out_data_byte  = res_r.data_byte;
  assign out_body_count = res_r.body_count;

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (res_r.kind != KIND_BODY) |-> out_data_byte == 8'd0)
    else $error("non-body result carries a data byte");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("decoded byte did not reach the result register");

  a_stall_holds_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r && $stable(in_byte_r))
    else $error("stalled input register lost its byte");

endmodule

FILE: test/hcbd_result_checker.sv
// Result checker for the chunked body decoder: predicts each result and compares it.
module hcbd_result_checker
  import hcbd_pkg::*;
#(
  parameter logic [CFG_ADDR_W-1:0] REG_CHUNKED_MODE   = 3'd0,
  parameter logic [CFG_ADDR_W-1:0] REG_CONTENT_LENGTH = 3'd4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [2:0]            out_kind,
  input  logic [7:0]            out_data_byte,
  input  logic [31:0]           out_body_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    mismatches,
  output int                    results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_W = LENGTH_WIDTH_DEF;

  typedef enum logic [2:0] {
    AT_SIZE_LINE,
    IN_CHUNK_DATA,
    AT_CHUNK_END,
    AT_FINAL_LINE,
    BODY_DONE,
    BODY_FAILED
  } frame_phase_t;

  logic             chunked;
  logic [31:0]      length_limit;
  frame_phase_t     phase;
  logic [LEN_W-1:0] chunk_left;
  logic [LEN_W-1:0] size_acc;
  logic             have_digits;
  logic             digits_closed;
  logic             cr_held;
  logic [31:0]      delivered;
  result_t          due_results[$];

  task automatic flag_mismatch(input string what);
    $display("%0t ns: decoder result mismatch: %s", $time, what);
    mismatches++;
  endtask

  // {is_hex, value}
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if (folded >= "a" && folded <= "f") return {1'b1, folded[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic void new_line();
    size_acc      = '0;
    have_digits   = 1'b0;
    digits_closed = 1'b0;
    cr_held       = 1'b0;
  endfunction

  function automatic void count_body_byte();
    if (delivered != LEN_ALL_ONES) delivered++;
  endfunction

  // Fold one size-line byte into the size; low on overflow.
  function automatic logic take_size_char(input logic [7:0] c);
    logic [4:0] h;
    h = hex_of(c);
    if (digits_closed) return 1'b1;
    if (h[4]) begin
      if (size_acc[LEN_W-1 -: 4] != 4'd0) return 1'b0;
      size_acc    = {size_acc[LEN_W-5:0], h[3:0]};
      have_digits = 1'b1;
    end else if (have_digits || (c != CHAR_SP && c != CHAR_TAB)) begin
      digits_closed = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic kind_t chunked_kind(input logic [7:0] c);
    case (phase)
      AT_SIZE_LINE: begin
        if (cr_held) begin
          cr_held = 1'b0;
          if (c == CHAR_LF) begin
            if (!have_digits) begin
              phase = BODY_FAILED;
              return KIND_ERROR;
            end
            if (size_acc == '0) begin
              phase = AT_FINAL_LINE;
            end else begin
              chunk_left = size_acc;
              phase      = IN_CHUNK_DATA;
            end
            new_line();
            return KIND_FRAME;
          end
          void'(take_size_char(CHAR_CR));
        end else if (c == CHAR_CR) begin
          cr_held = 1'b1;
          return KIND_FRAME;
        end
        if (!take_size_char(c)) begin
          phase = BODY_FAILED;
          return KIND_ERROR;
        end
        return KIND_FRAME;
      end
      IN_CHUNK_DATA: begin
        count_body_byte();
        if (chunk_left != '0) chunk_left--;
        if (chunk_left == '0) phase = AT_CHUNK_END;
        return KIND_BODY;
      end
      AT_CHUNK_END, AT_FINAL_LINE: begin
        if (cr_held) begin
          cr_held = 1'b0;
          if (c == CHAR_LF) begin
            if (phase == AT_FINAL_LINE) begin
              phase = BODY_DONE;
              return KIND_END;
            end
            phase = AT_SIZE_LINE;
            new_line();
            return KIND_FRAME;
          end
          phase = BODY_FAILED;
          return KIND_ERROR;
        end
        if (c == CHAR_CR) begin
          cr_held = 1'b1;
          return KIND_FRAME;
        end
        phase = BODY_FAILED;
        return KIND_ERROR;
      end
      BODY_DONE: return KIND_IGNORE;
      default: begin
        phase = BODY_FAILED;
        return KIND_ERROR;
      end
    endcase
  endfunction

  function automatic result_t decode_byte(input logic [7:0] c);
    result_t r;
    if (chunked) begin
      r.kind = chunked_kind(c);
    end else if (length_limit == LEN_ALL_ONES || delivered < length_limit) begin
      count_body_byte();
      r.kind = KIND_BODY;
    end else begin
      r.kind = KIND_IGNORE;
    end
    r.data_byte  = (r.kind == KIND_BODY) ? c : 8'd0;
    r.body_count = delivered;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      chunked      = 1'b0;
      length_limit = LEN_ALL_ONES;
      phase        = AT_SIZE_LINE;
      chunk_left   = '0;
      delivered    = '0;
      new_line();
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("result kind %0d with none due", out_kind));
        end else begin
          want = due_results.pop_front();
          if (out_kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
          if (out_data_byte !== want.data_byte)
            flag_mismatch($sformatf("data_byte %0h, want %0h", out_data_byte, want.data_byte));
          if (out_body_count !== want.body_count)
            flag_mismatch($sformatf("body_count %0d, want %0d", out_body_count,
                                    want.body_count));
        end
      end
      if (in_valid && !in_stall) due_results.push_back(decode_byte(in_byte));
      if (psel && penable && pwrite && pready) begin
        if (paddr == REG_CHUNKED_MODE) chunked = pwdata[0];
        else if (paddr == REG_CONTENT_LENGTH) length_limit = pwdata;
      end
    end
    results_due = due_results.size();
  end

endmodule

FILE: test/http_chunked_body_decoder_tb.sv
// Testbench top for the chunked body decoder: byte stream, APB writes, pacing and verdict.
module http_chunked_body_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hcbd_pkg::*;

  // Register map: one 32-bit register per word.
  localparam logic [CFG_ADDR_W-1:0] REG_CHUNKED_MODE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CONTENT_LENGTH = 3'd4;

  localparam int STIMULUS_BYTES = 625;  // directed part plus about 600 random requests
  localparam int WATCHDOG_LIMIT = 2000; // quiet cycles before the run is declared hung
  localparam int TAIL_CYCLES    = 8;    // wait after the drain so stray results can show
  localparam int PACE_HEAVY     = 62;
  localparam int PACE_BOTH      = 28;

  localparam string HEX_CHARS = "0123456789abcdefABCDEF";

  // How the single chunked body is brought to its end; reset is never reapplied.
  typedef enum int {
    TAIL_CLEAN_END,
    TAIL_NO_DIGITS,
    TAIL_SIZE_OVERFLOW,
    TAIL_DIRTY_CHUNK_END,
    TAIL_DIRTY_FINAL_LINE,
    TAIL_OPEN_CHUNK
  } body_tail_t;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte  = 8'd0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            out_kind;
  logic [7:0]            out_data_byte;
  logic [31:0]           out_body_count;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int          mismatches;
  int          results_due;
  int          bytes_sent     = 0;
  int          quiet_cycles   = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic [31:0] last_count     = '0;
  logic [7:0]  burst[$];

  always #5 clk = ~clk;

  http_chunked_body_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_body_count (out_body_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  hcbd_result_checker #(
    .REG_CHUNKED_MODE   (REG_CHUNKED_MODE),
    .REG_CONTENT_LENGTH (REG_CONTENT_LENGTH)
  ) result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_body_count (out_body_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .results_due    (results_due)
  );

  // Stall the result side at random, at whatever rate the current burst asks for.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Track the running body count for content_length choices, and watch for a hang:
  // any request, result or APB access counts as progress.
  always @(posedge clk) begin
    if (out_valid && !out_stall) last_count <= out_body_count;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("http_chunked_body_decoder_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // All driving tasks are entered just after a falling edge at which nothing has been
  // assigned yet, and leave the same way, so no signal is assigned twice in one step.

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one byte request, after a random idle gap, and hold it until taken.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
  endtask

  // Send the queued bytes under one randomly chosen pacing style.
  task automatic play_burst();
    case ($urandom_range(0, 3))
      0: begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      1: begin
        src_idle_pct   = PACE_HEAVY;
        sink_stall_pct = 0;
      end
      2: begin
        src_idle_pct   = 0;
        sink_stall_pct = PACE_HEAVY;
      end
      default: begin
        src_idle_pct   = PACE_BOTH;
        sink_stall_pct = PACE_BOTH;
      end
    endcase
    foreach (burst[i]) push_byte(burst[i]);
    burst.delete();
  endtask

  task automatic add_line_end();
    burst.push_back(CHAR_CR);
    burst.push_back(CHAR_LF);
  endtask

  task automatic add_random(input int n, input logic no_cr);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom()); while (no_cr && b == CHAR_CR);
      burst.push_back(b);
    end
  endtask

  // Any content byte, or a CR that is not followed by LF, where an empty line is due.
  task automatic add_dirty_line();
    logic [7:0] b;
    if ($urandom_range(0, 1)) begin
      add_random(1, 1'b1);
    end else begin
      burst.push_back(CHAR_CR);
      do b = 8'($urandom()); while (b == CHAR_LF);
      burst.push_back(b);
    end
  endtask

  // Size line: optional blanks and leading zeros, hex in mixed case, and sometimes an
  // extension opened by a non-hex byte, possibly holding a stray CR.
  task automatic add_size_line(input logic [31:0] size);
    string      digits;
    logic [7:0] c;
    repeat ($urandom_range(0, 2)) burst.push_back($urandom_range(0, 1) ? CHAR_SP : CHAR_TAB);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) burst.push_back("0");
    end
    digits = $sformatf("%0h", size);
    for (int i = 0; i < digits.len(); i++) begin
      c = digits[i];
      if (c >= "a" && $urandom_range(0, 1)) c = c - 8'h20;
      burst.push_back(c);
    end
    if ($urandom_range(0, 1)) begin
      do c = 8'($urandom());
      while (c == CHAR_CR || (c >= "0" && c <= "9") || ((c | 8'h20) >= "a" && (c | 8'h20) <= "f"));
      burst.push_back(c);
      add_random($urandom_range(0, 6), 1'b1);
      if ($urandom_range(0, 3) == 0) begin
        burst.push_back(CHAR_CR);
        do c = 8'($urandom()); while (c == CHAR_CR || c == CHAR_LF);
        burst.push_back(c);
      end
    end
    add_line_end();
  endtask

  initial begin
    int          size;
    int          first;
    logic [31:0] limit;
    body_tail_t  tail;

    // Hold reset at the start, then release it once for the whole run.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Identity mode, unlimited length: extreme and alternating bytes all pass.
    write_reg(REG_CONTENT_LENGTH, LEN_ALL_ONES);
    write_reg(REG_CHUNKED_MODE, 1'b0);
    burst = '{8'h00, 8'hff, 8'h55, 8'haa};
    play_burst();
    drain();

    // Zero length: everything is ignored.
    write_reg(REG_CONTENT_LENGTH, '0);
    add_random(2, 1'b0);
    play_burst();
    drain();

    // Length two beyond the current count: two bytes pass, the third is ignored.
    write_reg(REG_CONTENT_LENGTH, last_count + 32'd2);
    add_random(3, 1'b0);
    play_burst();
    drain();

    // Chunked: leading blanks and a leading zero, an extension whose hex letter is
    // ignored, a CR followed by another byte, then CR and LF carried as chunk data.
    write_reg(REG_CHUNKED_MODE, 1'b1);
    burst = '{CHAR_TAB, CHAR_SP, "0", "2", ";", "e", CHAR_CR, "x", CHAR_CR, CHAR_LF,
              CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};
    play_burst();

    // Random part: mostly well-formed chunks, with identity bursts and mode switches
    // in the middle of a chunk. Mode is chunked again at the end of each pass.
    while (bytes_sent < STIMULUS_BYTES) begin
      case ($urandom_range(0, 9))
        0: begin
          drain();
          write_reg(REG_CHUNKED_MODE, 1'b0);
          case ($urandom_range(0, 4))
            0:       limit = LEN_ALL_ONES;
            1:       limit = '0;
            2:       limit = $urandom();
            default: limit = last_count + 32'($urandom_range(0, 12));
          endcase
          write_reg(REG_CONTENT_LENGTH, limit);
          add_random($urandom_range(4, 30), 1'b0);
          play_burst();
          drain();
          write_reg(REG_CHUNKED_MODE, 1'b1);
        end
        1: begin
          // Split a chunk: switch to identity mid-data, then resume the chunk.
          size  = $urandom_range(2, 24);
          first = $urandom_range(1, size - 1);
          add_size_line(size);
          add_random(first, 1'b0);
          play_burst();
          drain();
          write_reg(REG_CHUNKED_MODE, 1'b0);
          add_random($urandom_range(1, 8), 1'b0);
          play_burst();
          drain();
          write_reg(REG_CHUNKED_MODE, 1'b1);
          add_random(size - first, 1'b0);
          add_line_end();
          play_burst();
        end
        default: begin
          size = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 16);
          add_size_line(size);
          add_random(size, 1'b0);
          add_line_end();
          play_burst();
        end
      endcase
    end

    // Close the body or leave a chunk open, then keep sending: later bytes are ignored
    // after a clean end, flagged after an error and taken as data in an open chunk.
    tail = body_tail_t'($urandom_range(0, 5));
    case (tail)
      TAIL_CLEAN_END: begin
        add_size_line(0);
        add_line_end();
      end
      TAIL_NO_DIGITS: begin
        if ($urandom_range(0, 1)) burst = '{CHAR_SP, ";", "x"};
        add_line_end();
      end
      TAIL_SIZE_OVERFLOW: begin
        // Nine significant digits: the ninth would carry past 32 bits.
        burst.push_back(HEX_CHARS[$urandom_range(1, 21)]);
        repeat (8) burst.push_back(HEX_CHARS[$urandom_range(0, 21)]);
      end
      TAIL_DIRTY_CHUNK_END: begin
        size = $urandom_range(1, 8);
        add_size_line(size);
        add_random(size, 1'b0);
        add_dirty_line();
      end
      TAIL_DIRTY_FINAL_LINE: begin
        add_size_line(0);
        add_dirty_line();
      end
      default: begin
        // Largest size the counter holds; the chunk never finishes.
        add_size_line(LEN_ALL_ONES);
      end
    endcase
    add_random($urandom_range(10, 20), 1'b0);
    play_burst();

    // Let every result out, then give stray results a chance to show.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("http_chunked_body_decoder_tb: done, clean");
    end else begin
      $display("http_chunked_body_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
